[src/hsum_pkg.sv]
// ----------------------------------------------------------------------------
// Histogram summary statistics package
// Field widths, default sizes, controller states and the command and status
// bundles shared by the controller and the datapath.
// ----------------------------------------------------------------------------
package hsum_pkg;

   // Default sizes for the top-level parameters
   localparam int NUM_BINS_DEF       = 256;
   localparam int COUNT_BITS_DEF     = 30;
   localparam int MEAN_FRAC_BITS_DEF = 16;

   // Fixed field widths on the stream ports
   localparam int CIN_BITS = 30;
   localparam int MIN_W    = 9;
   localparam int MAX_W    = 8;
   localparam int MEAN_W   = 24;
   localparam int MED_W    = 9;
   localparam int MODE_W   = 9;

   localparam int REQ_DATA_W  = ((CIN_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_W = MIN_W + MAX_W + MEAN_W + MED_W + MODE_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [3:0] {
      ST_STREAM = 4'b0001,
      ST_MEDIAN = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_LOAD   = 4'b1000
   } hsum_state_type;

   typedef struct packed {
      logic bin_accept;
      logic med_run;
      logic div_start;
      logic div_run;
      logic load_out;
   } hsum_cmd_type;

   typedef struct packed {
      logic med_done;
      logic div_done;
      logic out_free;
   } hsum_status_type;

endpackage

[src/hsum_ram.sv]
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module hsum_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/hsum_ctrl.sv]
// ----------------------------------------------------------------------------
// Histogram summary statistics controller
// Sequences the bin stream, the median pass, the mean division and the
// hand-off of each result into the output register.
// ----------------------------------------------------------------------------
module hsum_ctrl import hsum_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_last,
   output logic            req_ready,
   output hsum_cmd_type    cmd,
   input  hsum_status_type status
);

   hsum_state_type state_ff;
   hsum_state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_STREAM);
      unique case (state_ff)
         ST_STREAM: begin
            cmd.bin_accept = req_valid;
            if (req_valid && req_last) begin
               state_in = ST_MEDIAN;
            end
         end
         ST_MEDIAN: begin
            cmd.med_run = 1'b1;
            if (status.med_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_run = 1'b1;
            if (status.div_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_STREAM;
            end
         end
         default: begin
            state_in = ST_STREAM;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_STREAM;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/hsum_datapath.sv]
// ----------------------------------------------------------------------------
// Histogram summary statistics datapath
// Running min, max, mode, total and weighted sum; median pass over the bin
// store; restoring divider for the mean; output register.
// ----------------------------------------------------------------------------
module hsum_datapath import hsum_pkg::*; #(
   parameter int NUM_BINS       = NUM_BINS_DEF,
   parameter int COUNT_BITS     = COUNT_BITS_DEF,
   parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  hsum_cmd_type                cmd,
   output hsum_status_type             status,
   input  logic [CIN_BITS-1:0]         bin_count,
   // bin store
   output logic                        ram_we,
   output logic [$clog2(NUM_BINS)-1:0] ram_waddr,
   output logic [CIN_BITS-1:0]         ram_wdata,
   output logic [$clog2(NUM_BINS)-1:0] ram_raddr,
   input  logic [CIN_BITS-1:0]         ram_rdata,
   // result
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [MIN_W-1:0]            min_value,
   output logic [MAX_W-1:0]            max_value,
   output logic [MEAN_W-1:0]           mean_fixed,
   output logic [MED_W-1:0]            median_doubled,
   output logic [MODE_W-1:0]           mode_value,
   output logic                        count_overflow
);

   localparam int IDX_BITS     = $clog2(NUM_BINS);
   localparam int IDX_CNT_BITS = $clog2(NUM_BINS + 1);
   localparam int SUM_BITS     = ((COUNT_BITS > CIN_BITS) ? COUNT_BITS : CIN_BITS) + 1;
   localparam int WSUM_BITS    = COUNT_BITS + IDX_BITS;
   localparam int PROD_BITS    = IDX_BITS + CIN_BITS;
   localparam int DIV_BITS     = WSUM_BITS + MEAN_FRAC_BITS;
   localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
   localparam int QUO_BITS     = IDX_BITS + MEAN_FRAC_BITS;
   localparam int ACC_BITS     = IDX_BITS + 1;

   localparam logic [IDX_CNT_BITS-1:0] BIN_LIMIT = IDX_CNT_BITS'(NUM_BINS);
   localparam logic [SUM_BITS-1:0]     COUNT_MAX =
      {{(SUM_BITS - COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};
   localparam logic [DIV_CNT_BITS-1:0] DIV_STEPS = DIV_CNT_BITS'(DIV_BITS);

   // running statistics
   logic [IDX_CNT_BITS-1:0] bin_index_ff, bin_index_in;
   logic                    min_found_ff, min_found_in;
   logic [IDX_BITS-1:0]     min_idx_ff, min_idx_in;
   logic [IDX_BITS-1:0]     max_idx_ff, max_idx_in;
   logic                    mode_found_ff, mode_found_in;
   logic [IDX_BITS-1:0]     mode_idx_ff, mode_idx_in;
   logic [CIN_BITS-1:0]     mode_cnt_ff, mode_cnt_in;
   logic [COUNT_BITS-1:0]   total_ff, total_in;
   logic                    ovf_ff, ovf_in;
   logic [WSUM_BITS-1:0]    wsum_ff, wsum_in;
   logic                    add_ff, add_in;
   logic [PROD_BITS-1:0]    prod_ff, prod_in;

   // median pass
   logic [IDX_CNT_BITS-1:0] med_addr_ff, med_addr_in;
   logic                    rd_valid_ff, rd_valid_in;
   logic [IDX_BITS-1:0]     rd_idx_ff;
   logic [SUM_BITS-1:0]     seen_ff, seen_in;
   logic [ACC_BITS-1:0]     acc_ff, acc_in;

   // divider
   logic [COUNT_BITS-1:0]   rem_ff, rem_in;
   logic [DIV_BITS-1:0]     dsh_ff, dsh_in;
   logic [QUO_BITS-1:0]     quo_ff, quo_in;
   logic [DIV_CNT_BITS-1:0] dcnt_ff, dcnt_in;

   // output register
   logic                    out_valid_ff, out_valid_in;
   logic [MIN_W-1:0]        min_out_ff;
   logic [MAX_W-1:0]        max_out_ff;
   logic [MEAN_W-1:0]       mean_out_ff;
   logic [MED_W-1:0]        med_out_ff;
   logic [MODE_W-1:0]       mode_out_ff;
   logic                    ovf_out_ff;

   logic                          in_range;
   logic [IDX_BITS-1:0]           bin_idx;
   logic [SUM_BITS-1:0]           sum_w;
   logic                          sum_over;
   logic [WSUM_BITS+PROD_BITS-1:0] prod_wide;
   logic                          issue;
   logic [SUM_BITS-1:0]           lo_w, hi_w, next_w;
   logic                          hit_lo, hit_hi;
   logic [ACC_BITS-1:0]           rd_idx_ext;
   logic [COUNT_BITS:0]           rem_sh, dvs, rem_diff;
   logic                          rem_ge;
   logic [IDX_BITS+MIN_W-1:0]     min_wide;
   logic [IDX_BITS+MAX_W-1:0]     max_wide;
   logic [QUO_BITS+MEAN_W-1:0]    quo_wide;
   logic [ACC_BITS+MED_W-1:0]     acc_wide;
   logic [IDX_BITS+MODE_W-1:0]    mode_wide;

   assign in_range  = (bin_index_ff < BIN_LIMIT);
   assign bin_idx   = bin_index_ff[IDX_BITS-1:0];
   assign sum_w     = SUM_BITS'(total_ff) + SUM_BITS'(bin_count);
   assign sum_over  = (sum_w > COUNT_MAX);
   assign prod_in   = PROD_BITS'(bin_idx) * PROD_BITS'(bin_count);
   assign prod_wide = {{WSUM_BITS{1'b0}}, prod_ff};

   assign ram_we    = cmd.bin_accept && in_range;
   assign ram_waddr = bin_idx;
   assign ram_wdata = bin_count;
   assign ram_raddr = med_addr_ff[IDX_BITS-1:0];

   // median: lower and upper middle ranks
   assign issue      = cmd.med_run && (med_addr_ff < bin_index_ff);
   assign lo_w       = (SUM_BITS'(total_ff) + SUM_BITS'(1)) >> 1;
   assign hi_w       = (SUM_BITS'(total_ff) + SUM_BITS'(2)) >> 1;
   assign next_w     = seen_ff + SUM_BITS'(ram_rdata);
   assign hit_lo     = rd_valid_ff && (seen_ff < lo_w) && (next_w >= lo_w);
   assign hit_hi     = rd_valid_ff && (seen_ff < hi_w) && (next_w >= hi_w);
   assign rd_idx_ext = ACC_BITS'(rd_idx_ff);

   // one restoring division step per cycle
   assign rem_sh   = {rem_ff, dsh_ff[DIV_BITS-1]};
   assign dvs      = {1'b0, total_ff};
   assign rem_ge   = (rem_sh >= dvs);
   assign rem_diff = rem_sh - dvs;

   assign min_wide  = {{MIN_W{1'b0}}, min_idx_ff};
   assign max_wide  = {{MAX_W{1'b0}}, max_idx_ff};
   assign quo_wide  = {{MEAN_W{1'b0}}, quo_ff};
   assign acc_wide  = {{MED_W{1'b0}}, acc_ff};
   assign mode_wide = {{MODE_W{1'b0}}, mode_idx_ff};

   always_comb begin
      bin_index_in  = bin_index_ff;
      min_found_in  = min_found_ff;
      min_idx_in    = min_idx_ff;
      max_idx_in    = max_idx_ff;
      mode_found_in = mode_found_ff;
      mode_idx_in   = mode_idx_ff;
      mode_cnt_in   = mode_cnt_ff;
      total_in      = total_ff;
      ovf_in        = ovf_ff;
      wsum_in       = wsum_ff;
      add_in        = 1'b0;
      med_addr_in   = med_addr_ff;
      rd_valid_in   = issue;
      seen_in       = seen_ff;
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      dsh_in        = dsh_ff;
      quo_in        = quo_ff;
      dcnt_in       = dcnt_ff;
      out_valid_in  = out_valid_ff && !out_ready;

      if (add_ff) begin
         wsum_in = wsum_ff + prod_wide[WSUM_BITS-1:0];
      end

      if (cmd.bin_accept && in_range) begin
         bin_index_in = bin_index_ff + IDX_CNT_BITS'(1);
         if (bin_count != '0) begin
            max_idx_in = bin_idx;
            if (!min_found_ff) begin
               min_found_in = 1'b1;
               min_idx_in   = bin_idx;
            end
            if (bin_count > mode_cnt_ff) begin
               mode_found_in = 1'b1;
               mode_idx_in   = bin_idx;
               mode_cnt_in   = bin_count;
            end
            if (!ovf_ff) begin
               if (sum_over) begin
                  total_in = {COUNT_BITS{1'b1}};
                  ovf_in   = 1'b1;
               end else begin
                  total_in = sum_w[COUNT_BITS-1:0];
                  add_in   = 1'b1;
               end
            end
         end
      end

      if (issue) begin
         med_addr_in = med_addr_ff + IDX_CNT_BITS'(1);
      end
      if (rd_valid_ff) begin
         seen_in = next_w;
         acc_in  = acc_ff + (hit_lo ? rd_idx_ext : '0) + (hit_hi ? rd_idx_ext : '0);
      end

      if (cmd.div_start) begin
         dsh_in  = {wsum_ff, {MEAN_FRAC_BITS{1'b0}}};
         rem_in  = '0;
         quo_in  = '0;
         dcnt_in = DIV_STEPS;
      end else if (cmd.div_run && (dcnt_ff != '0)) begin
         rem_in  = rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
         quo_in  = {quo_ff[QUO_BITS-2:0], rem_ge};
         dsh_in  = dsh_ff << 1;
         dcnt_in = dcnt_ff - DIV_CNT_BITS'(1);
      end

      if (cmd.load_out) begin
         out_valid_in  = 1'b1;
         // clear statistics for the next histogram
         bin_index_in  = '0;
         min_found_in  = 1'b0;
         max_idx_in    = '0;
         mode_found_in = 1'b0;
         mode_cnt_in   = '0;
         total_in      = '0;
         ovf_in        = 1'b0;
         wsum_in       = '0;
         med_addr_in   = '0;
         seen_in       = '0;
         acc_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bin_index_ff  <= '0;
         min_found_ff  <= 1'b0;
         max_idx_ff    <= '0;
         mode_found_ff <= 1'b0;
         mode_cnt_ff   <= '0;
         total_ff      <= '0;
         ovf_ff        <= 1'b0;
         wsum_ff       <= '0;
         add_ff        <= 1'b0;
         med_addr_ff   <= '0;
         rd_valid_ff   <= 1'b0;
         seen_ff       <= '0;
         acc_ff        <= '0;
         dcnt_ff       <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         bin_index_ff  <= bin_index_in;
         min_found_ff  <= min_found_in;
         max_idx_ff    <= max_idx_in;
         mode_found_ff <= mode_found_in;
         mode_cnt_ff   <= mode_cnt_in;
         total_ff      <= total_in;
         ovf_ff        <= ovf_in;
         wsum_ff       <= wsum_in;
         add_ff        <= add_in;
         med_addr_ff   <= med_addr_in;
         rd_valid_ff   <= rd_valid_in;
         seen_ff       <= seen_in;
         acc_ff        <= acc_in;
         dcnt_ff       <= dcnt_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_idx_ff  <= min_idx_in;
      mode_idx_ff <= mode_idx_in;
      prod_ff     <= prod_in;
      rd_idx_ff   <= ram_raddr;
      rem_ff      <= rem_in;
      dsh_ff      <= dsh_in;
      quo_ff      <= quo_in;
      if (cmd.load_out) begin
         min_out_ff  <= min_found_ff ? min_wide[MIN_W-1:0] : {MIN_W{1'b1}};
         max_out_ff  <= max_wide[MAX_W-1:0];
         mean_out_ff <= (ovf_ff || (total_ff == '0)) ? '0 : quo_wide[MEAN_W-1:0];
         med_out_ff  <= ovf_ff ? '0 : acc_wide[MED_W-1:0];
         mode_out_ff <= mode_found_ff ? mode_wide[MODE_W-1:0] : {MODE_W{1'b1}};
         ovf_out_ff  <= ovf_ff;
      end
   end

   assign status.med_done = (med_addr_ff == bin_index_ff) && !rd_valid_ff;
   assign status.div_done = (dcnt_ff == '0);
   assign status.out_free = !out_valid_ff || out_ready;

   assign out_valid      = out_valid_ff;
   assign min_value      = min_out_ff;
   assign max_value      = max_out_ff;
   assign mean_fixed     = mean_out_ff;
   assign median_doubled = med_out_ff;
   assign mode_value     = mode_out_ff;
   assign count_overflow = ovf_out_ff;

endmodule

[src/histogram_summary_statistics.sv]
// ----------------------------------------------------------------------------
// Histogram summary statistics
// Takes the bins of a histogram and returns min, max, mean, median and mode.
// ----------------------------------------------------------------------------
// Input stream (req_*): one bin count per transfer, bin 0 first, req_tlast on
// the final bin. Bins beyond NUM_BINS are dropped; their tlast still ends
// the histogram. Bins are taken at one per cycle while req_tready is high.
// Result stream (rsp_*): one transfer per histogram.
// After the last bin the block runs the median pass over the stored bins
// (one bin store read per cycle), then the restoring divider for the mean
// (one quotient bit per cycle), then loads the output register once it is
// free. req_tready is low during that time.
// The output register holds a result until rsp_tready; the next histogram
// streams in meanwhile, and its result waits for the register to drain.
// Reset clears all statistics and drops any pending result; the bin store
// needs no clearing since only bins of the current histogram are read.
// ----------------------------------------------------------------------------
module histogram_summary_statistics import hsum_pkg::*; #(
   parameter int NUM_BINS       = NUM_BINS_DEF,
   parameter int COUNT_BITS     = COUNT_BITS_DEF,
   parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // bin_count
   input  logic                  req_tlast,   // last_bin
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // min_value, max_value, mean_fixed, median_doubled, mode_value
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser    // count_overflow
);

   localparam int IDX_BITS = $clog2(NUM_BINS);

   hsum_cmd_type    cmd;
   hsum_status_type status;

   logic                ram_we;
   logic [IDX_BITS-1:0] ram_waddr;
   logic [CIN_BITS-1:0] ram_wdata;
   logic [IDX_BITS-1:0] ram_raddr;
   logic [CIN_BITS-1:0] ram_rdata;

   logic [MIN_W-1:0]  min_value;
   logic [MAX_W-1:0]  max_value;
   logic [MEAN_W-1:0] mean_fixed;
   logic [MED_W-1:0]  median_doubled;
   logic [MODE_W-1:0] mode_value;

   hsum_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .cmd       (cmd),
      .status    (status)
   );

   hsum_datapath #(
      .NUM_BINS       (NUM_BINS),
      .COUNT_BITS     (COUNT_BITS),
      .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .bin_count      (req_tdata[CIN_BITS-1:0]),
      .ram_we         (ram_we),
      .ram_waddr      (ram_waddr),
      .ram_wdata      (ram_wdata),
      .ram_raddr      (ram_raddr),
      .ram_rdata      (ram_rdata),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .min_value      (min_value),
      .max_value      (max_value),
      .mean_fixed     (mean_fixed),
      .median_doubled (median_doubled),
      .mode_value     (mode_value),
      .count_overflow (rsp_tuser)
   );

   hsum_ram #(
      .WIDTH (CIN_BITS),
      .DEPTH (NUM_BINS)
   ) u_bin_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}},
                       mode_value, median_doubled, mean_fixed, max_value, min_value};

endmodule

[src/hsum_checker.sv]
// ----------------------------------------------------------------------------
// Histogram summary statistics checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module hsum_checker import hsum_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tuser
);

   logic [MIN_W-1:0]  min_f;
   logic [MAX_W-1:0]  max_f;
   logic [MEAN_W-1:0] mean_f;
   logic [MED_W-1:0]  med_f;
   logic [MODE_W-1:0] mode_f;

   assign min_f  = rsp_tdata[MIN_W-1:0];
   assign max_f  = rsp_tdata[MIN_W+MAX_W-1:MIN_W];
   assign mean_f = rsp_tdata[MIN_W+MAX_W+MEAN_W-1:MIN_W+MAX_W];
   assign med_f  = rsp_tdata[MIN_W+MAX_W+MEAN_W+MED_W-1:MIN_W+MAX_W+MEAN_W];
   assign mode_f = rsp_tdata[RSP_FIELD_W-1:MIN_W+MAX_W+MEAN_W+MED_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // overflow forces mean and median to zero
   a_ovf_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (mean_f == '0) && (med_f == '0))
      else $error("mean or median nonzero on overflow");

   // an empty histogram reports no mode and zero max, mean and median
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (min_f == {MIN_W{1'b1}}) |->
         (mode_f == {MODE_W{1'b1}}) && (max_f == '0) && (mean_f == '0) && (med_f == '0))
      else $error("empty histogram result inconsistent");

   // the doubled median lies between twice the min and twice the max
   a_med_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser && (min_f != {MIN_W{1'b1}}) |->
         ({1'b0, med_f} >= {1'b0, min_f, 1'b0}) && ({1'b0, med_f} <= {1'b0, max_f, 1'b0}))
      else $error("median outside min and max");

endmodule

bind histogram_summary_statistics hsum_checker u_hsum_checker (.*);
